>>> hw/rtl/lbs_pkg.sv
// Package for the lower-bound search block.
// Holds shared widths, codes, the controller state type and the control/status structs.
// No dependencies.
`default_nettype none

package lbs_pkg;

   localparam int LBS_DEPTH      = 1024;
   localparam int COUNT_WIDTH    = 11;
   localparam int IDX_WIDTH      = 10;
   localparam int DATA_WIDTH     = 32;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   localparam logic REG_ELEMENT_COUNT = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic start;
      logic step;
      logic rd_en;
      logic out_load;
      logic out_from_step;
   } ctl_type;

   typedef struct packed {
      logic n_zero;
      logic search_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/lbs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module lbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/lbs_ctrl.sv
// Controller state machine for the lower-bound search.
// Depends on lbs_pkg; drives the datapath through ctl_type and reads status_type.
`default_nettype none

module lbs_ctrl
   import lbs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_cmd,
   output logic            req_stall,
   input  wire status_type status,
   output ctl_type         ctl
);

   state_type state_ff;
   state_type state_in;
   logic      is_query;

   assign is_query = (req_cmd == CMD_QUERY);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && is_query) begin
               state_in = status.n_zero ? ST_HOLD : ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (status.search_done) begin
               state_in = status.out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            ctl.wr_en = req_valid && !is_query;
            ctl.start = req_valid && is_query;
            ctl.rd_en = req_valid && is_query;
         end
         ST_PROBE: begin
            ctl.step          = 1'b1;
            ctl.out_from_step = 1'b1;
            ctl.rd_en         = !status.search_done;
            ctl.out_load      = status.search_done && status.out_free;
         end
         ST_HOLD: begin
            ctl.out_load = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/lbs_dpath.sv
// Datapath for the lower-bound search: table RAM, search bounds, probe index and result register.
// Depends on lbs_pkg and lbs_ram.
`default_nettype none

module lbs_dpath
   import lbs_pkg::*;
#(
   parameter int DEPTH = LBS_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic        [IDX_WIDTH-1:0]   req_entry_index,
   input  wire logic signed [DATA_WIDTH-1:0]  req_entry_value,
   input  wire logic signed [DATA_WIDTH-1:0]  req_search_key,
   input  wire logic        [COUNT_WIDTH-1:0] element_count,
   input  wire ctl_type                       ctl,
   output status_type                         status,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output logic             [COUNT_WIDTH-1:0] rsp_position
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = COUNT_WIDTH;

   function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] lo, input logic [CW-1:0] hi);
      logic [CW:0] half;
      logic [CW:0] sum;
      half = ({1'b0, hi - lo} + (CW+1)'(1)) >> 1;
      sum  = {1'b0, lo} + half - (CW+1)'(1);
      return sum[CW-1:0];
   endfunction

   logic        [CW-1:0]         lo_ff, lo_in;
   logic        [CW-1:0]         hi_ff, hi_in;
   logic        [CW-1:0]         mid_ff, mid_in;
   logic signed [DATA_WIDTH-1:0] key_ff, key_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic        [CW-1:0]         position_ff, position_in;

   logic        [CW-1:0]         n_sat;
   logic                         ge;
   logic        [CW-1:0]         lo_step, hi_step;
   logic        [CW-1:0]         rd_mid;
   logic        [AW+CW-1:0]      rd_wide;
   logic        [AW+IDX_WIDTH-1:0] wr_wide;
   logic                         wr_ok;
   logic        [DATA_WIDTH-1:0] rd_data;
   logic                         out_free;

   assign n_sat = (32'(element_count) > 32'(DEPTH)) ? CW'(DEPTH) : element_count;

   assign ge      = ($signed(rd_data) >= key_ff);
   assign hi_step = ge ? mid_ff : hi_ff;
   assign lo_step = ge ? lo_ff : (mid_ff + CW'(1));

   assign rd_mid  = ctl.start ? mid_of('0, n_sat) : mid_of(lo_step, hi_step);
   assign rd_wide = {{AW{1'b0}}, rd_mid};
   assign wr_wide = {{AW{1'b0}}, req_entry_index};
   assign wr_ok   = ctl.wr_en && (32'(req_entry_index) < 32'(DEPTH));

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign status.n_zero      = (n_sat == '0);
   assign status.search_done = !(hi_step > lo_step);
   assign status.out_free    = out_free;

   lbs_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_ok),
      .wr_addr(wr_wide[AW-1:0]),
      .wr_data(req_entry_value),
      .rd_en  (ctl.rd_en),
      .rd_addr(rd_wide[AW-1:0]),
      .rd_data(rd_data)
   );

   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      mid_in = mid_ff;
      key_in = key_ff;
      if (ctl.start) begin
         lo_in  = '0;
         hi_in  = n_sat;
         mid_in = rd_mid;
         key_in = req_search_key;
      end else if (ctl.step) begin
         lo_in  = lo_step;
         hi_in  = hi_step;
         mid_in = rd_mid;
      end
   end

   assign rsp_valid_in = ctl.out_load || (rsp_valid_ff && rsp_stall);
   assign position_in  = ctl.out_load ? (ctl.out_from_step ? hi_step : hi_ff) : position_ff;

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      key_ff      <= key_in;
      position_ff <= position_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = position_ff;

endmodule

`default_nettype wire

>>> hw/rtl/lower_bound_search.sv
// Top level of the lower-bound search block: register port, controller and datapath.
// Depends on lbs_pkg, lbs_ctrl and lbs_dpath.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  cmd, entry_index, entry_value, search_key
//   rsp      out        rsp_valid/rsp_stall  position
//   csr      in/out     APB-style, pready=1  element_count at byte address 0
//
// A write item is accepted in IDLE and the next item can follow at once.
// A query item is accepted in IDLE, then probes the table RAM in PROBE, making
// ceil(log2(n+1)) probes for n = min(element_count, DEPTH), or goes to HOLD when n is 0.
// The probes run one after another on the single RAM read port. The result is registered;
// while the output is stalled, a finished search waits in HOLD until it drains.
// Reset clears the control state and element_count; the table is undefined until written.
`default_nettype none

module lower_bound_search
   import lbs_pkg::*;
#(
   parameter int DEPTH = LBS_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_cmd,
   input  wire logic        [IDX_WIDTH-1:0]      req_entry_index,
   input  wire logic signed [DATA_WIDTH-1:0]     req_entry_value,
   input  wire logic signed [DATA_WIDTH-1:0]     req_search_key,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic             [COUNT_WIDTH-1:0]    rsp_position,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic        [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic        [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic             [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                  csr_pready
);

   logic [COUNT_WIDTH-1:0] element_count_ff, element_count_in;
   logic                   csr_wr;
   logic                   csr_sel_count;
   ctl_type                ctl;
   status_type             status;

   assign csr_pready    = 1'b1;
   assign csr_sel_count = (csr_paddr[2] == REG_ELEMENT_COUNT);
   assign csr_wr        = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign element_count_in = (csr_wr && csr_sel_count) ? csr_pwdata[COUNT_WIDTH-1:0]
                                                        : element_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         element_count_ff <= '0;
      end else begin
         element_count_ff <= element_count_in;
      end
   end

   assign csr_prdata = csr_sel_count ? CSR_DATA_WIDTH'(element_count_ff) : '0;

   lbs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_cmd  (req_cmd),
      .req_stall(req_stall),
      .status   (status),
      .ctl      (ctl)
   );

   lbs_dpath #(
      .DEPTH(DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_entry_index(req_entry_index),
      .req_entry_value(req_entry_value),
      .req_search_key (req_search_key),
      .element_count  (element_count_ff),
      .ctl            (ctl),
      .status         (status),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_position   (rsp_position)
   );

`ifndef ASSERT_OFF
   a_position_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_position <= element_count_ff))
      else $error("result position exceeds element_count");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_cmd == CMD_QUERY)) |=> req_stall)
      else $error("input not stalled after a query item");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_cmd == CMD_WRITE)) |=> !$rose(rsp_valid))
      else $error("write item produced a result");

   a_single_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.wr_en, ctl.start, ctl.out_load}))
      else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

>>> verif/lbs_position_check.sv
// Position checker for the lower-bound search block: watches the item, result and register ports.
// Keeps its own table and element count, predicts each query's position and compares results.
// Depends on lbs_pkg.
`timescale 1ns / 1ps

module lbs_position_check
   import lbs_pkg::*;
(
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire logic                             req_cmd,
   input  wire logic        [IDX_WIDTH-1:0]      req_entry_index,
   input  wire logic signed [DATA_WIDTH-1:0]     req_entry_value,
   input  wire logic signed [DATA_WIDTH-1:0]     req_search_key,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire logic        [COUNT_WIDTH-1:0]    rsp_position,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic        [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic        [CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  wire logic                             csr_pready,
   output int                                    error_count,
   output int                                    pending_results
);

   localparam logic [CSR_ADDR_WIDTH-1:0] COUNT_ADDR = CSR_ADDR_WIDTH'(4 * REG_ELEMENT_COUNT);

   logic signed [DATA_WIDTH-1:0]  entry_mem [LBS_DEPTH];
   logic        [COUNT_WIDTH-1:0] element_count = '0;
   logic        [COUNT_WIDTH-1:0] expected_positions [$];

   initial error_count = 0;
   initial pending_results = 0;

   // The probe sequence is followed exactly, so an unsorted table gives the same answer as the block.
   function automatic logic [COUNT_WIDTH-1:0] lower_bound_position(
      input logic signed [DATA_WIDTH-1:0] key
   );
      int lo;
      int hi;
      int mid;
      lo = -1;
      hi = (element_count > LBS_DEPTH) ? LBS_DEPTH : int'(element_count);
      while (hi - lo > 1) begin
         mid = lo + (hi - lo) / 2;
         if (entry_mem[mid] >= key) begin
            hi = mid;
         end else begin
            lo = mid;
         end
      end
      return COUNT_WIDTH'(hi);
   endfunction

   always @(posedge clock) begin : watch
      logic [COUNT_WIDTH-1:0] wanted;
      if (reset) begin
         element_count = '0;
         expected_positions.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_positions.size() == 0) begin
               $error("position: result with nothing expected, actual %0d", rsp_position);
               error_count <= error_count + 1;
            end else begin
               wanted = expected_positions.pop_front();
               if (rsp_position !== wanted) begin
                  $error("position mismatch: expected %0d, actual %0d", wanted, rsp_position);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_cmd == CMD_QUERY) begin
               expected_positions.push_back(lower_bound_position(req_search_key));
            end else begin
               entry_mem[req_entry_index] = req_entry_value;
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == COUNT_ADDR) begin
            element_count = csr_pwdata[COUNT_WIDTH-1:0];
         end
      end
      pending_results <= expected_positions.size();
   end

endmodule

>>> verif/lower_bound_search_tb.sv
// Top of the lower-bound search testbench: clock, reset, item stimulus and the final verdict.
// Depends on lbs_pkg, lower_bound_search and lbs_position_check.
`timescale 1ns / 1ps

module lower_bound_search_tb
   import lbs_pkg::*;
();

   localparam int LIMIT_CYCLES = 1000000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_ITEMS = 1100;
   localparam logic [CSR_ADDR_WIDTH-1:0] COUNT_ADDR = CSR_ADDR_WIDTH'(4 * REG_ELEMENT_COUNT);
   localparam logic signed [DATA_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_WIDTH-1:0] VALUE_MAX = 32'sh7fff_ffff;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic                             req_cmd = CMD_WRITE;
   logic        [IDX_WIDTH-1:0]      req_entry_index = '0;
   logic signed [DATA_WIDTH-1:0]     req_entry_value = '0;
   logic signed [DATA_WIDTH-1:0]     req_search_key = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic        [COUNT_WIDTH-1:0]    rsp_position;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic        [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic        [CSR_DATA_WIDTH-1:0] csr_pwdata = '0;
   logic        [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                             csr_pready;

   int   error_count;
   int   pending_results;
   int   cycle_count = 0;
   int   stall_left = 0;
   int   sent_items = 0;
   logic calm = 1'b0;

   logic signed [DATA_WIDTH-1:0] shadow_entries [LBS_DEPTH];
   bit                           entry_written [LBS_DEPTH];

   lower_bound_search uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_position    (rsp_position),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   lbs_position_check position_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_position    (rsp_position),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // After each accepted result the receiver may assert rsp_stall for a random draw; when calm it does not.
   always @(posedge clock) begin : rsp_backpressure
      int draw;
      draw = calm ? 0 : $urandom_range(0, 3);
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         rsp_stall <= (draw != 0);
         stall_left <= draw;
      end else if (stall_left > 0) begin
         rsp_stall <= (stall_left > 1);
         stall_left <= stall_left - 1;
      end
   end

   task automatic send_item(
      input cmd_type                      cmd,
      input logic [IDX_WIDTH-1:0]         index,
      input logic signed [DATA_WIDTH-1:0] value,
      input logic signed [DATA_WIDTH-1:0] key
   );
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_entry_index <= index;
      req_entry_value <= value;
      req_search_key <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items = sent_items + 1;
   endtask

   task automatic write_entry(input int index, input logic signed [DATA_WIDTH-1:0] value);
      shadow_entries[index] = value;
      entry_written[index] = 1'b1;
      send_item(CMD_WRITE, IDX_WIDTH'(index), value, $urandom);
   endtask

   task automatic run_query(input logic signed [DATA_WIDTH-1:0] key);
      send_item(CMD_QUERY, IDX_WIDTH'($urandom_range(0, LBS_DEPTH - 1)), $urandom, key);
   endtask

   // The count register is only written once the block has drained.
   task automatic set_count(input int count_value);
      logic [CSR_DATA_WIDTH-1:0] word;
      word = $urandom;
      word[COUNT_WIDTH-1:0] = count_value[COUNT_WIDTH-1:0];
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= COUNT_ADDR;
      csr_pwdata <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      int     count_value;
      int     used;
      int     pick;
      int     n_items;
      int     step_max;
      int     delta;
      int     raw;
      bit     all_written;
      bit     unsorted;
      longint level;
      longint key_wide;
      logic signed [DATA_WIDTH-1:0] key;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // An empty table always answers zero.
      run_query(VALUE_MAX);
      run_query(VALUE_MIN);

      write_entry(0, VALUE_MIN);
      write_entry(1, -1);
      write_entry(2, 0);
      write_entry(3, 0);
      write_entry(4, VALUE_MAX);
      write_entry(LBS_DEPTH - 1, VALUE_MAX);

      set_count(5);
      run_query(VALUE_MIN);
      run_query(VALUE_MIN + 1);
      run_query(-1);
      run_query(0);
      run_query(1);
      run_query(VALUE_MAX);

      // No entry reaches the key, so the answer is the count itself.
      set_count(4);
      run_query(VALUE_MAX);

      // An out-of-order entry breaks the sort; the probe sequence still decides.
      write_entry(2, VALUE_MIN);
      run_query(0);
      run_query(-1);

      while (sent_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            count_value = 0;
         end else if (pick < 58) begin
            count_value = $urandom_range(1, 16);
         end else if (pick < 78) begin
            count_value = $urandom_range(17, 200);
         end else if (pick < 86) begin
            count_value = LBS_DEPTH;
         end else if (pick < 92) begin
            count_value = $urandom_range(0, 1) ? 2047 : $urandom_range(LBS_DEPTH + 1, 2046);
         end else begin
            count_value = $urandom_range(201, LBS_DEPTH - 1);
         end
         used = (count_value > LBS_DEPTH) ? LBS_DEPTH : count_value;
         calm <= ($urandom_range(0, 4) == 0);
         set_count(count_value);

         all_written = 1'b1;
         for (int i = 0; i < used; i++) begin
            if (!entry_written[i]) all_written = 1'b0;
         end
         pick = $urandom_range(0, 99);
         if (!all_written || (used <= 200 && pick < 85)) begin
            unsorted = all_written && pick >= 70;
            case ($urandom_range(0, 4))
               0: step_max = 0;
               1: step_max = 1;
               2: step_max = 7;
               3: step_max = 1 << 16;
               default: step_max = 1 << 26;
            endcase
            case ($urandom_range(0, 3))
               0: level = VALUE_MIN;
               1: level = int'($urandom_range(0, 64)) - 32;
               default: begin
                  raw = $urandom;
                  level = raw;
               end
            endcase
            for (int i = 0; i < used; i++) begin
               if (unsorted) begin
                  raw = $urandom;
                  write_entry(i, $urandom_range(0, 1) ? raw : DATA_WIDTH'(level + $urandom_range(0, 15)));
               end else begin
                  write_entry(i, DATA_WIDTH'(level));
                  level = level + $urandom_range(0, step_max);
                  if (level > longint'(VALUE_MAX)) level = VALUE_MAX;
               end
            end
         end

         n_items = $urandom_range(10, 40);
         for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(0, 4) == 0) begin
               if (used > 0 && $urandom_range(0, 9) < 6) begin
                  write_entry($urandom_range(0, used - 1), $urandom);
               end else begin
                  write_entry($urandom_range(0, LBS_DEPTH - 1), $urandom);
               end
            end else begin
               pick = $urandom_range(0, 99);
               if (used > 0 && pick < 55) begin
                  delta = $urandom_range(0, 2);
                  key_wide = longint'(shadow_entries[$urandom_range(0, used - 1)]) + delta - 1;
                  if (key_wide > longint'(VALUE_MAX)) key_wide = VALUE_MAX;
                  if (key_wide < longint'(VALUE_MIN)) key_wide = VALUE_MIN;
                  key = DATA_WIDTH'(key_wide);
               end else if (pick < 80) begin
                  key = $urandom;
               end else if (pick < 90) begin
                  key = VALUE_MIN;
               end else begin
                  key = VALUE_MAX;
               end
               run_query(key);
            end
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/lbs_pkg.sv
hw/rtl/lbs_ram.sv
hw/rtl/lbs_ctrl.sv
hw/rtl/lbs_dpath.sv
hw/rtl/lower_bound_search.sv
verif/lbs_position_check.sv
verif/lower_bound_search_tb.sv
